// ===== src/c_subset_token_scanner_assert.svh =====
// assertion macros shared by the scanner checker
`ifndef C_SUBSET_TOKEN_SCANNER_ASSERT_SVH
`define C_SUBSET_TOKEN_SCANNER_ASSERT_SVH

// checked at every edge, reset included
`define CTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset
`define CTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== src/cts_pkg.sv =====
// types, codes and tables of the c subset token scanner
`timescale 1ns / 1ps

package cts_pkg;

  localparam int WORD_MAX_DEFAULT = 8;
  localparam int KEYWORD_COUNT    = 7;
  localparam int KW_CHARS         = 5;
  localparam int TQ_DEPTH         = 4;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // token kinds
  localparam logic [5:0] KIND_ADD     = 6'd0;
  localparam logic [5:0] KIND_SUB     = 6'd1;
  localparam logic [5:0] KIND_MUL     = 6'd2;
  localparam logic [5:0] KIND_DIV     = 6'd3;
  localparam logic [5:0] KIND_MOD     = 6'd4;
  localparam logic [5:0] KIND_INC     = 6'd5;
  localparam logic [5:0] KIND_DEC     = 6'd6;
  localparam logic [5:0] KIND_EQ      = 6'd7;
  localparam logic [5:0] KIND_NE      = 6'd8;
  localparam logic [5:0] KIND_GT      = 6'd9;
  localparam logic [5:0] KIND_LT      = 6'd10;
  localparam logic [5:0] KIND_GE      = 6'd11;
  localparam logic [5:0] KIND_LE      = 6'd12;
  localparam logic [5:0] KIND_AND     = 6'd13;
  localparam logic [5:0] KIND_ORR     = 6'd14;
  localparam logic [5:0] KIND_NOT     = 6'd15;
  localparam logic [5:0] KIND_ASS     = 6'd16;
  localparam logic [5:0] KIND_ADA     = 6'd17;
  localparam logic [5:0] KIND_SBA     = 6'd18;
  localparam logic [5:0] KIND_MLA     = 6'd19;
  localparam logic [5:0] KIND_DVA     = 6'd20;
  localparam logic [5:0] KIND_MDA     = 6'd21;
  localparam logic [5:0] KIND_STRING  = 6'd22;
  localparam logic [5:0] KIND_ID      = 6'd23;
  localparam logic [5:0] KIND_NUM     = 6'd24;
  localparam logic [5:0] KIND_KW0     = 6'd25;
  localparam logic [5:0] KIND_SPECIAL = 6'd32;

  localparam logic [7:0] CH_NONE = 8'd0;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_ADD    = 4'd1,
    MODE_SUB    = 4'd2,
    MODE_MUL    = 4'd3,
    MODE_DIV    = 4'd4,
    MODE_MOD    = 4'd5,
    MODE_ASSIGN = 4'd6,
    MODE_NOT    = 4'd7,
    MODE_GT     = 4'd8,
    MODE_LT     = 4'd9,
    MODE_AMP    = 4'd10,
    MODE_BAR    = 4'd11,
    MODE_WORD   = 4'd12,
    MODE_NUM    = 4'd13,
    MODE_STR    = 4'd14
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] lead;
    logic [5:0] one_kind;
    logic [7:0] next_a;
    logic [5:0] kind_a;
    logic [7:0] next_b;
    logic [5:0] kind_b;
  } op_row_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  spec;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } token_t;

  // keyword text, first character in the highest used byte
  localparam logic [KW_CHARS-1:0][7:0] KW_TEXT [KEYWORD_COUNT] = '{
    "int", "if", "else", "while", "for", "char", "do"
  };
  localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
    3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd2
  };

  function automatic op_row_t op_row(scan_mode_t m);
    op_row_t r;
    r = '0;
    case (m)
      MODE_ADD:    r = '{"+", KIND_ADD,     "+", KIND_INC, "=", KIND_ADA};
      MODE_SUB:    r = '{"-", KIND_SUB,     "-", KIND_DEC, "=", KIND_SBA};
      MODE_MUL:    r = '{"*", KIND_MUL,     "=", KIND_MLA, CH_NONE, KIND_ADD};
      MODE_DIV:    r = '{"/", KIND_DIV,     "=", KIND_DVA, CH_NONE, KIND_ADD};
      MODE_MOD:    r = '{"%", KIND_MOD,     "=", KIND_MDA, CH_NONE, KIND_ADD};
      MODE_ASSIGN: r = '{"=", KIND_ASS,     "=", KIND_EQ,  CH_NONE, KIND_ADD};
      MODE_NOT:    r = '{"!", KIND_NOT,     "=", KIND_NE,  CH_NONE, KIND_ADD};
      MODE_GT:     r = '{">", KIND_GT,      "=", KIND_GE,  CH_NONE, KIND_ADD};
      MODE_LT:     r = '{"<", KIND_LT,      "=", KIND_LE,  CH_NONE, KIND_ADD};
      MODE_AMP:    r = '{"&", KIND_SPECIAL, "&", KIND_AND, CH_NONE, KIND_ADD};
      MODE_BAR:    r = '{"|", KIND_SPECIAL, "|", KIND_ORR, CH_NONE, KIND_ADD};
      default:     r = '0;
    endcase
    return r;
  endfunction

  function automatic scan_mode_t op_mode(logic [7:0] ch);
    scan_mode_t m;
    case (ch)
      "+":     m = MODE_ADD;
      "-":     m = MODE_SUB;
      "*":     m = MODE_MUL;
      "/":     m = MODE_DIV;
      "%":     m = MODE_MOD;
      "=":     m = MODE_ASSIGN;
      "!":     m = MODE_NOT;
      ">":     m = MODE_GT;
      "<":     m = MODE_LT;
      "&":     m = MODE_AMP;
      "|":     m = MODE_BAR;
      default: m = MODE_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic is_letter(logic [7:0] ch);
    return ch inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_num_char(logic [7:0] ch);
    return ch inside {["0":"9"], "."};
  endfunction

  // only the first characters of the word can match a keyword
  function automatic logic [5:0] keyword_kind(logic [KW_CHARS-1:0][7:0] head,
                                              logic [5:0] len, logic overlong);
    logic [5:0] kind;
    logic       same;
    kind = KIND_ID;
    if (!overlong) begin
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
        same = (6'(KW_LEN[k]) == len);
        for (int i = 0; i < KW_CHARS; i++) begin
          if (i < int'(KW_LEN[k])) begin
            if (head[i] != KW_TEXT[k][int'(KW_LEN[k]) - 1 - i]) begin
              same = 1'b0;
            end
          end
        end
        if (same) begin
          kind = KIND_KW0 + 6'(k);
        end
      end
    end
    return kind;
  endfunction

  function automatic token_t make_token(logic [5:0] kind, logic [7:0] ch,
                                        logic [15:0] row, logic [15:0] col);
    token_t t;
    t.kind = kind;
    t.spec = (kind == KIND_SPECIAL) ? ch : 8'd0;
    t.row  = row;
    t.col  = col;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

// ===== src/c_subset_token_scanner.sv =====
// c subset token scanner: characters in, tokens with start row and column out
`timescale 1ns / 1ps

// Streaming lexical scanner. One character is taken per input transaction;
// tlast on the input marks end of text, flushes any pending token and
// returns the block to its reset state (the character is then ignored).
// Each input transaction yields zero, one or two tokens: two when a pending
// token is ended by a character that itself is a lone special token. The
// scan of a character is combinational, so one character per clock is taken
// while at least two entries of the four-entry token queue are free; tokens
// wait in that queue, so a stalled output stops the input once fewer than two
// queue entries are free. Rows start at 1, columns at 1, both saturate at
// 65535. Keywords are int, if, else, while, for, char, do; words longer than
// WORD_MAX letters are identifiers.
module c_subset_token_scanner import cts_pkg::*; #(
  parameter int WORD_MAX = WORD_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] special_char, [23:8] token_row, [39:24] token_col
  output logic [5:0]  m_tuser,   // [5:0] token_kind
  output logic        m_tlast    // last_of_run
);

  localparam int LEN_W = $clog2(WORD_MAX + 1);
  localparam int PTR_W = $clog2(TQ_DEPTH);
  localparam int CNT_W = $clog2(TQ_DEPTH + 1);

  // scanner state
  scan_mode_t       mode, mode_next;
  logic [7:0]       word_buffer [WORD_MAX];
  logic [LEN_W-1:0] word_length, word_length_next;
  logic             word_overlong, word_overlong_next;
  logic [15:0]      current_row, current_row_next;
  logic [15:0]      current_col, current_col_next;
  logic [15:0]      start_row, start_row_next;
  logic [15:0]      start_col, start_col_next;

  // token queue
  token_t           tq [TQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] tq_count;

  logic             accept, pop;
  logic [7:0]       ch;
  logic [15:0]      pos, row_inc;
  op_row_t          cur_op;
  logic [KW_CHARS-1:0][7:0] word_head;
  logic [5:0]       word_kind;

  logic             flush_valid;
  logic [5:0]       flush_kind;
  logic [7:0]       flush_spec;
  token_t           flush_tok, fresh_tok, single_tok;
  logic             single_valid, restart;

  logic             fresh_ws, fresh_emit;
  scan_mode_t       fresh_op, fresh_mode;

  logic             buf_we;
  logic [LEN_W-1:0] buf_idx;
  token_t           tok_a, tok_b;
  logic [1:0]       n_tok, push_n;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign ch       = s_tdata;
  assign s_tready = (tq_count <= CNT_W'(TQ_DEPTH - 2));

  // next column, and next row for a newline, both saturating
  assign pos     = (current_col != SAT16) ? current_col + 16'd1 : current_col;
  assign row_inc = (current_row != SAT16) ? current_row + 16'd1 : current_row;

  always_comb begin
    for (int i = 0; i < KW_CHARS; i++) begin
      word_head[i] = word_buffer[i];
    end
  end

  assign word_kind = keyword_kind(word_head, 6'(word_length), word_overlong);
  assign cur_op    = op_row(mode);

  // pending token as it stands, when nothing more joins it
  always_comb begin
    flush_valid = 1'b1;
    flush_kind  = KIND_ID;
    flush_spec  = 8'd0;
    case (mode)
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_ASSIGN,
      MODE_NOT, MODE_GT, MODE_LT, MODE_AMP, MODE_BAR: begin
        flush_kind = cur_op.one_kind;
        flush_spec = cur_op.lead;
      end
      MODE_WORD: flush_kind = word_kind;
      MODE_NUM:  flush_kind = KIND_NUM;
      MODE_STR:  flush_kind = KIND_STRING;
      default:   flush_valid = 1'b0;
    endcase
    flush_tok = make_token(flush_kind, flush_spec, start_row, start_col);
  end

  // the character scanned as the start of a new token
  always_comb begin
    fresh_ws   = ch inside {" ", "\t", "\n"};
    fresh_op   = op_mode(ch);
    fresh_emit = 1'b0;
    if (fresh_ws) begin
      fresh_mode = MODE_IDLE;
    end else if (ch == "\"") begin
      fresh_mode = MODE_STR;
    end else if (fresh_op != MODE_IDLE) begin
      fresh_mode = fresh_op;
    end else if (is_letter(ch)) begin
      fresh_mode = MODE_WORD;
    end else if (is_num_char(ch)) begin
      fresh_mode = MODE_NUM;
    end else begin
      fresh_mode = MODE_IDLE;
      fresh_emit = 1'b1;
    end
    fresh_tok = make_token(KIND_SPECIAL, ch, current_row, pos);
  end

  // one pass over the accepted character
  always_comb begin
    mode_next          = mode;
    word_length_next   = word_length;
    word_overlong_next = word_overlong;
    current_row_next   = current_row;
    current_col_next   = current_col;
    start_row_next     = start_row;
    start_col_next     = start_col;
    buf_we             = 1'b0;
    buf_idx            = word_length;
    single_valid       = 1'b0;
    single_tok         = flush_tok;
    restart            = 1'b0;
    tok_a              = flush_tok;
    tok_b              = fresh_tok;
    n_tok              = 2'd0;

    if (s_tlast) begin
      // end of text: flush, then back to reset values
      n_tok              = flush_valid ? 2'd1 : 2'd0;
      mode_next          = MODE_IDLE;
      word_length_next   = '0;
      word_overlong_next = 1'b0;
      current_row_next   = 16'd1;
      current_col_next   = 16'd0;
      start_row_next     = 16'd1;
      start_col_next     = 16'd0;
    end else begin
      case (mode)
        MODE_STR: begin
          if (ch == "\"") begin
            single_valid = 1'b1;
            mode_next    = MODE_IDLE;
          end
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_ASSIGN,
        MODE_NOT, MODE_GT, MODE_LT, MODE_AMP, MODE_BAR: begin
          if (cur_op.next_a != CH_NONE && ch == cur_op.next_a) begin
            single_valid = 1'b1;
            single_tok   = make_token(cur_op.kind_a, CH_NONE, start_row, start_col);
            mode_next    = MODE_IDLE;
          end else if (cur_op.next_b != CH_NONE && ch == cur_op.next_b) begin
            single_valid = 1'b1;
            single_tok   = make_token(cur_op.kind_b, CH_NONE, start_row, start_col);
            mode_next    = MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_letter(ch)) begin
            if (word_length < LEN_W'(WORD_MAX)) begin
              buf_we           = 1'b1;
              word_length_next = word_length + LEN_W'(1);
            end else begin
              word_overlong_next = 1'b1;
            end
          end else begin
            restart = 1'b1;
          end
        end
        MODE_NUM: begin
          if (!is_num_char(ch)) begin
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        mode_next = fresh_mode;
        if (!fresh_ws) begin
          start_row_next = current_row;
          start_col_next = pos;
        end
        if (fresh_mode == MODE_WORD) begin
          buf_we             = 1'b1;
          buf_idx            = '0;
          word_length_next   = LEN_W'(1);
          word_overlong_next = 1'b0;
        end
      end

      // pending token first, then a lone special from the fresh scan
      if (single_valid) begin
        tok_a = single_tok;
        n_tok = 2'd1;
      end else if (restart) begin
        if (flush_valid) begin
          n_tok = fresh_emit ? 2'd2 : 2'd1;
        end else if (fresh_emit) begin
          tok_a = fresh_tok;
          n_tok = 2'd1;
        end
      end

      if (ch == "\n") begin
        current_row_next = row_inc;
        current_col_next = 16'd0;
      end else begin
        current_col_next = pos;
      end
    end

    tok_a.last = (n_tok == 2'd1);
    tok_b.last = 1'b1;
  end

  assign push_n = accept ? n_tok : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      word_length   <= '0;
      word_overlong <= 1'b0;
      current_row   <= 16'd1;
      current_col   <= 16'd0;
      start_row     <= 16'd1;
      start_col     <= 16'd0;
    end else if (accept) begin
      mode          <= mode_next;
      word_length   <= word_length_next;
      word_overlong <= word_overlong_next;
      current_row   <= current_row_next;
      current_col   <= current_col_next;
      start_row     <= start_row_next;
      start_col     <= start_col_next;
    end
  end

  // word letters, no reset: only entries below word_length affect a token
  always_ff @(posedge clk) begin
    for (int i = 0; i < WORD_MAX; i++) begin
      if (accept && buf_we && buf_idx == LEN_W'(i)) begin
        word_buffer[i] <= ch;
      end
    end
  end

  // token queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      tq_count <= '0;
    end else begin
      wr_ptr   <= wr_ptr + PTR_W'(push_n);
      rd_ptr   <= rd_ptr + PTR_W'(pop);
      tq_count <= tq_count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      tq[wr_ptr] <= tok_a;
    end
    if (push_n == 2'd2) begin
      tq[wr_ptr + PTR_W'(1)] <= tok_b;
    end
  end

  assign m_tvalid = (tq_count != '0);
  assign m_tuser  = tq[rd_ptr].kind;
  assign m_tdata  = {tq[rd_ptr].col, tq[rd_ptr].row, tq[rd_ptr].spec};
  assign m_tlast  = tq[rd_ptr].last;

endmodule

// ===== src/cts_checker.sv =====
// port-level checks of the token scanner, bound to its top level
`timescale 1ns / 1ps
`include "c_subset_token_scanner_assert.svh"

module cts_checker import cts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [5:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled token transaction holds
  `CTS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "token changed while stalled")

  // the queue is empty after reset, so input is open
  `CTS_ASSERT_ALWAYS(a_ready_after_rst, rst |=> s_tready && !m_tvalid, "not ready after reset")

  // special character field only set on special tokens
  `CTS_ASSERT(a_spec_zero, m_tvalid && m_tuser != KIND_SPECIAL |-> m_tdata[7:0] == 8'd0, "special_char set on a non-special token")

  // every token starts at a real position and has a known kind
  `CTS_ASSERT(a_pos_valid, m_tvalid |-> m_tdata[23:8] != 16'd0 && m_tdata[39:24] != 16'd0 && m_tuser <= KIND_SPECIAL, "bad token position or kind")

endmodule

bind c_subset_token_scanner cts_checker u_cts_checker (.*);
